@@ design/char_lcd_nibble_sequencer_defines.svh @@
// Assertion helpers shared by the sequencer checks.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CLNS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CLNS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/clns_pkg.sv @@
package clns_pkg;

  // Request codes.
  localparam logic [2:0] CMD_BYTE   = 3'd0;
  localparam logic [2:0] CMD_DATA   = 3'd1;
  localparam logic [2:0] CMD_CURSOR = 3'd2;
  localparam logic [2:0] CMD_GLYPH  = 3'd3;
  localparam logic [2:0] CMD_INIT   = 3'd4;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_HOLD       = 2'd0;
  localparam logic [1:0] REG_CLEAR      = 2'd1;
  localparam logic [1:0] REG_INIT_PAUSE = 2'd2;
  localparam logic [1:0] REG_POWER_UP   = 2'd3;

  // Reset values of the registers.
  localparam logic [11:0] HOLD_RST       = 12'd100;
  localparam logic [15:0] CLEAR_RST      = 16'd2000;
  localparam logic [15:0] INIT_PAUSE_RST = 16'd4000;
  localparam logic [15:0] POWER_UP_RST   = 16'd15000;

  // Command bytes.
  localparam logic [7:0] LCD_CLEAR      = 8'h01;
  localparam logic [7:0] LCD_SET_DDRAM  = 8'h80;
  localparam logic [7:0] LCD_SET_CGRAM  = 8'h40;

  // Step numbers. Byte requests use HIGH then LOW; init walks 0 to 12.
  localparam logic [3:0] STEP_HIGH       = 4'd0;
  localparam logic [3:0] STEP_LOW        = 4'd1;
  localparam logic [3:0] STEP_POWER      = 4'd0;
  localparam logic [3:0] STEP_INIT_FIRST = 4'd1;
  localparam logic [3:0] STEP_INIT_CLEAR = 4'd10;
  localparam logic [3:0] STEP_INIT_LAST  = 4'd12;

  typedef struct packed {
    logic [11:0] hold_us;
    logic [15:0] clear_extra_us;
    logic [15:0] init_pause_us;
    logic [15:0] power_up_us;
  } cfg_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data;
  } req_t;

  typedef struct packed {
    logic [3:0]  nibble;
    logic        reg_sel;
    logic        strobe_res;
    logic [16:0] wait_after_us;
    logic        last;
  } res_t;

  // Byte that a request sends; init ignores it.
  function automatic logic [7:0] req_byte(input logic [2:0] cmd, input logic [7:0] value,
                                          input logic [5:0] column, input logic row,
                                          input logic [2:0] glyph_slot);
    logic [6:0] addr;
    logic [7:0] b;
    addr = {1'b0, column} + {row, 6'd0};
    case (cmd)
      CMD_CURSOR: b = LCD_SET_DDRAM | {1'b0, addr};
      CMD_GLYPH:  b = LCD_SET_CGRAM | {2'b00, glyph_slot, 3'b000};
      default:    b = value;
    endcase
    return b;
  endfunction

  // Nibbles of the init sequence: 3,3,3,2 then 0x28, 0x0C, 0x01, 0x06.
  function automatic logic [3:0] init_nibble(input logic [3:0] step);
    logic [3:0] n;
    case (step)
      4'd1, 4'd2, 4'd3: n = 4'h3;
      4'd4, 4'd5:       n = 4'h2;
      4'd6:             n = 4'h8;
      4'd8:             n = 4'hC;
      4'd10:            n = 4'h1;
      4'd12:            n = 4'h6;
      default:          n = 4'h0;
    endcase
    return n;
  endfunction

endpackage

@@ design/clns_step.sv @@
module clns_step (
  input  clns_pkg::req_t req,
  input  logic [3:0]     step,
  input  clns_pkg::cfg_t cfg,
  output clns_pkg::res_t res
);
  import clns_pkg::*;

  logic [15:0] extra;

  // Extra wait added on top of the hold time for this step.
  always_comb begin
    extra = 16'd0;
    if (req.cmd == CMD_INIT) begin
      if (step == STEP_INIT_FIRST) begin
        extra = cfg.init_pause_us;
      end else if (step == STEP_INIT_CLEAR) begin
        extra = cfg.clear_extra_us;
      end
    end else if (step == STEP_LOW && req.cmd != CMD_DATA && req.data == LCD_CLEAR) begin
      extra = cfg.clear_extra_us;
    end
  end

  // One bus transfer for the current step.
  always_comb begin
    res.wait_after_us = {5'd0, cfg.hold_us} + {1'b0, extra};
    res.strobe_res    = 1'b1;
    if (req.cmd == CMD_INIT) begin
      res.reg_sel = 1'b0;
      res.nibble  = init_nibble(step);
      res.last    = (step == STEP_INIT_LAST);
      if (step == STEP_POWER) begin
        res.strobe_res    = 1'b0;
        res.wait_after_us = {1'b0, cfg.power_up_us};
      end
    end else begin
      res.reg_sel = (req.cmd == CMD_DATA);
      res.nibble  = (step == STEP_HIGH) ? req.data[7:4] : req.data[3:0];
      res.last    = (step == STEP_LOW);
    end
  end

endmodule

@@ design/char_lcd_nibble_sequencer.sv @@
// Character-LCD nibble sequencer, 4-bit bus.
// Input channel (in_valid/in_ready) takes one request word: cmd, value,
// column, row, glyph_slot, first_init. Output channel (out_valid/out_ready)
// gives one bus transfer per word: nibble, reg_sel, strobe_res,
// wait_after_us and last, which marks the final transfer of a request.
// A byte request gives two transfers in two-nibble mode, one before init;
// init gives 12 transfers, 13 with the power-up wait. Unknown codes give none.
// Registers sit at paddr 0, 4, 8, 12 of the APB port; pready is always high.
// The request register and one output register form the path: a request is
// loaded into the request register, then its first transfer into the output
// register. Transfers leave at one per cycle while the receiver does not stall;
// the next request is taken in the cycle of the final one.
// When the receiver stalls, the output register holds its word and the step
// counter stops; in_ready stays low until the last transfer can be loaded.
// Reset (synchronous, rst high) drops any request in flight, clears the
// output, loads the register defaults and returns to one-nibble mode.
`include "char_lcd_nibble_sequencer_defines.svh"

module char_lcd_nibble_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [7:0]  value,
  input  logic [5:0]  column,
  input  logic        row,
  input  logic [2:0]  glyph_slot,
  input  logic        first_init,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  nibble,
  output logic        reg_sel,
  output logic        strobe_res,
  output logic [16:0] wait_after_us,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import clns_pkg::*;

  cfg_t       cfg;
  logic       four_bit_mode;
  logic       busy;
  req_t       req;
  logic [3:0] step;
  res_t       res;
  res_t       out_res;
  logic       adv;
  logic       in_acc;
  logic       cmd_ok;
  logic       cfg_wr;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_us        <= HOLD_RST;
      cfg.clear_extra_us <= CLEAR_RST;
      cfg.init_pause_us  <= INIT_PAUSE_RST;
      cfg.power_up_us    <= POWER_UP_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_HOLD:       cfg.hold_us        <= pwdata[11:0];
        REG_CLEAR:      cfg.clear_extra_us <= pwdata[15:0];
        REG_INIT_PAUSE: cfg.init_pause_us  <= pwdata[15:0];
        REG_POWER_UP:   cfg.power_up_us    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      REG_HOLD:       prdata = {20'd0, cfg.hold_us};
      REG_CLEAR:      prdata = {16'd0, cfg.clear_extra_us};
      REG_INIT_PAUSE: prdata = {16'd0, cfg.init_pause_us};
      REG_POWER_UP:   prdata = {16'd0, cfg.power_up_us};
      default:        prdata = 32'd0;
    endcase
  end

  // Transfer for the current step.
  clns_step u_step (
    .req  (req),
    .step (step),
    .cfg  (cfg),
    .res  (res)
  );

  // Handshake: a step advances when the output register is free or drains.
  assign adv      = busy && (!out_valid || out_ready);
  assign in_ready = !busy || (adv && res.last);
  assign in_acc   = in_valid && in_ready;
  assign cmd_ok   = cmd inside {[CMD_BYTE:CMD_INIT]};

  // Request register, step counter and nibble mode.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      four_bit_mode <= 1'b0;
    end else if (in_acc) begin
      busy <= cmd_ok;
      if (cmd == CMD_INIT) begin
        four_bit_mode <= 1'b1;
      end
    end else if (adv && res.last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req.cmd  <= cmd;
      req.data <= req_byte(cmd, value, column, row, glyph_slot);
      if (cmd == CMD_INIT) begin
        step <= first_init ? STEP_POWER : STEP_INIT_FIRST;
      end else begin
        step <= four_bit_mode ? STEP_HIGH : STEP_LOW;
      end
    end else if (adv) begin
      step <= step + 4'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res;
    end
  end

  assign nibble        = out_res.nibble;
  assign reg_sel       = out_res.reg_sel;
  assign strobe_res    = out_res.strobe_res;
  assign wait_after_us = out_res.wait_after_us;
  assign last          = out_res.last;

  // Checks.
  `CLNS_ASSERT_NOW(a_ready_busy_last, busy && in_ready, adv && res.last, "ready while mid-request")
  `CLNS_ASSERT_NOW(a_step_range, busy, step <= STEP_INIT_LAST, "step counter out of range")
  `CLNS_ASSERT_NEXT(a_init_mode, in_acc && cmd == CMD_INIT, four_bit_mode, "init left one-nibble mode")
  `CLNS_ASSERT_NEXT(a_adv_loads, adv, out_valid, "advanced step did not load the output")

endmodule
